// File: rtl/ps2kt_pkg.sv
package ps2kt_pkg;

	localparam logic [7:0] RAW_SELF_TEST = 8'hAA;
	localparam logic [7:0] RAW_BREAK     = 8'hF0;
	localparam logic [7:0] RAW_EXTENDED  = 8'hE0;
	localparam int unsigned WORD_ROWS = 89;
	localparam int unsigned RAW_ROWS  = 132;
	localparam logic [7:0] KEYPAD_FIRST = 8'h47;

	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
	localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
	localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
	localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
	localparam logic [7:0] SC_CAPS         = 8'h3A;
	localparam logic [7:0] SC_SCROLL       = 8'h46;
	localparam logic [7:0] SC_NUM          = 8'h45;
	localparam logic [7:0] SC_INSERT       = 8'h52;
	localparam logic [7:0] SC_CAPS_BREAK   = 8'hBA;
	localparam logic [7:0] SC_SCROLL_BREAK = 8'hC6;
	localparam logic [7:0] SC_NUM_BREAK    = 8'hC5;
	localparam logic [7:0] SC_INSERT_BREAK = 8'hD2;

	typedef enum logic [2:0] {
		COL_NORMAL     = 3'd0,
		COL_SHIFT      = 3'd1,
		COL_CTRL       = 3'd2,
		COL_ALT        = 3'd3,
		COL_NUM        = 3'd4,
		COL_CAPS       = 3'd5,
		COL_SHIFT_CAPS = 3'd6,
		COL_SHIFT_NUM  = 3'd7
	} word_col_t;

	typedef struct packed {
		logic       left_shift;
		logic       right_shift;
		logic       ctrl;
		logic       alt;
		logic [3:0] locks;
	} mod_state_t;

	typedef struct packed {
		logic        key_valid;
		logic [15:0] key_word;
		logic        reply_needed;
		logic [7:0]  last_scan;
		mod_state_t  mods;
	} result_t;

	localparam logic [7:0] PLAIN_ROM [RAW_ROWS] = '{
		8'h00,8'h43,8'h00,8'h3F,8'h3D,8'h3B,8'h3C,8'h58,8'h00,8'h44,8'h42,8'h40,8'h3E,8'h0F,8'h29,8'h00,
		8'h00,8'h38,8'h2A,8'h00,8'h1D,8'h10,8'h02,8'h00,8'h00,8'h00,8'h2C,8'h1F,8'h1E,8'h11,8'h03,8'h00,
		8'h00,8'h2E,8'h2D,8'h20,8'h12,8'h05,8'h04,8'h00,8'h00,8'h39,8'h2F,8'h21,8'h14,8'h13,8'h06,8'h00,
		8'h00,8'h31,8'h30,8'h23,8'h22,8'h15,8'h07,8'h00,8'h00,8'h00,8'h32,8'h24,8'h16,8'h08,8'h09,8'h00,
		8'h00,8'h33,8'h25,8'h17,8'h18,8'h0B,8'h0A,8'h00,8'h00,8'h34,8'h35,8'h26,8'h27,8'h19,8'h0C,8'h00,
		8'h00,8'h00,8'h28,8'h00,8'h1A,8'h0D,8'h00,8'h00,8'h3A,8'h36,8'h1C,8'h1B,8'h00,8'h2B,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h0E,8'h00,8'h00,8'h02,8'h00,8'h05,8'h08,8'h00,8'h00,8'h00,
		8'h0B,8'h34,8'h03,8'h06,8'h07,8'h09,8'h01,8'h45,8'h57,8'h4E,8'h04,8'h4A,8'h37,8'h0A,8'h46,8'h00,
		8'h00,8'h00,8'h00,8'h41
	};

	localparam logic [15:0] WORD_ROM [WORD_ROWS][8] = '{
		'{16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000},
		'{16'h011B,16'h011B,16'h011B,16'h011B,16'h011B,16'h011B,16'h011B,16'h011B},
		'{16'h0231,16'h0221,16'h0000,16'h7800,16'h0231,16'h0231,16'h0221,16'h0221},
		'{16'h0332,16'h0340,16'h0300,16'h7900,16'h0332,16'h0332,16'h0340,16'h0340},
		'{16'h0433,16'h0423,16'h0000,16'h7A00,16'h0433,16'h0433,16'h0423,16'h0423},
		'{16'h0534,16'h0524,16'h0000,16'h7B00,16'h0534,16'h0534,16'h0524,16'h0524},
		'{16'h0635,16'h0625,16'h0000,16'h7C00,16'h0635,16'h0635,16'h0625,16'h0625},
		'{16'h0736,16'h075E,16'h071E,16'h7D00,16'h0736,16'h0736,16'h075E,16'h075E},
		'{16'h0837,16'h0826,16'h0000,16'h7E00,16'h0837,16'h0837,16'h0826,16'h0826},
		'{16'h0938,16'h092A,16'h0000,16'h7F00,16'h0938,16'h0938,16'h092A,16'h092A},
		'{16'h0A39,16'h0A28,16'h0000,16'h8000,16'h0A39,16'h0A39,16'h0A28,16'h0A28},
		'{16'h0B30,16'h0B29,16'h0000,16'h8100,16'h0B30,16'h0B30,16'h0B29,16'h0B29},
		'{16'h0C2D,16'h0C5F,16'h0000,16'h8200,16'h0C2D,16'h0C2D,16'h0C5F,16'h0C5F},
		'{16'h0D3D,16'h0D2B,16'h0000,16'h8300,16'h0D3D,16'h0D3D,16'h0D2B,16'h0D2B},
		'{16'h0E08,16'h0E08,16'h0E7F,16'h0000,16'h0E08,16'h0E08,16'h0E08,16'h0E08},
		'{16'h0F09,16'h0F00,16'h0000,16'h0000,16'h0F09,16'h0F09,16'h0F00,16'h0F00},
		'{16'h1071,16'h1051,16'h1011,16'h1000,16'h1071,16'h1051,16'h1071,16'h1051},
		'{16'h1177,16'h1157,16'h1117,16'h1100,16'h1177,16'h1157,16'h1177,16'h1157},
		'{16'h1265,16'h1245,16'h1205,16'h1200,16'h1265,16'h1245,16'h1265,16'h1245},
		'{16'h1372,16'h1352,16'h1312,16'h1300,16'h1372,16'h1352,16'h1372,16'h1352},
		'{16'h1474,16'h1454,16'h1414,16'h1400,16'h1474,16'h1454,16'h1474,16'h1454},
		'{16'h1579,16'h1559,16'h1519,16'h1500,16'h1579,16'h1559,16'h1579,16'h1559},
		'{16'h1675,16'h1655,16'h1615,16'h1600,16'h1675,16'h1655,16'h1675,16'h1655},
		'{16'h1769,16'h1749,16'h1709,16'h1700,16'h1769,16'h1749,16'h1769,16'h1749},
		'{16'h186F,16'h184F,16'h180F,16'h1800,16'h186F,16'h184F,16'h186F,16'h184F},
		'{16'h1970,16'h1950,16'h1910,16'h1900,16'h1970,16'h1950,16'h1970,16'h1950},
		'{16'h1A5B,16'h1A7B,16'h1A1B,16'h0000,16'h1A5B,16'h1A5B,16'h1A7B,16'h1A7B},
		'{16'h1B5D,16'h1B7D,16'h1B1D,16'h0000,16'h1B5D,16'h1B5D,16'h1B7D,16'h1B7D},
		'{16'h1C0D,16'h1C0D,16'h1C0A,16'h0000,16'h1C0D,16'h1C0D,16'h1C0D,16'h1C0D},
		'{16'h1D00,16'h1D00,16'h1D00,16'h1D00,16'h1D00,16'h1D00,16'h1D00,16'h1D00},
		'{16'h1E61,16'h1E41,16'h1E01,16'h1E00,16'h1E61,16'h1E41,16'h1E61,16'h1E41},
		'{16'h1F73,16'h1F53,16'h1F13,16'h1F00,16'h1F73,16'h1F53,16'h1F73,16'h1F53},
		'{16'h2064,16'h2044,16'h2004,16'h2000,16'h2064,16'h2044,16'h2064,16'h2044},
		'{16'h2166,16'h2146,16'h2106,16'h2100,16'h2166,16'h2146,16'h2166,16'h2146},
		'{16'h2267,16'h2247,16'h2207,16'h2200,16'h2267,16'h2247,16'h2267,16'h2247},
		'{16'h2368,16'h2348,16'h2308,16'h2300,16'h2368,16'h2348,16'h2368,16'h2348},
		'{16'h246A,16'h244A,16'h240A,16'h2400,16'h246A,16'h244A,16'h246A,16'h244A},
		'{16'h256B,16'h254B,16'h250B,16'h2500,16'h256B,16'h254B,16'h256B,16'h254B},
		'{16'h266C,16'h264C,16'h260C,16'h2600,16'h266C,16'h264C,16'h266C,16'h264C},
		'{16'h273B,16'h273A,16'h0000,16'h0000,16'h273B,16'h273B,16'h273A,16'h273A},
		'{16'h2827,16'h2822,16'h0000,16'h0000,16'h2827,16'h2827,16'h2822,16'h2822},
		'{16'h2960,16'h297E,16'h0000,16'h0000,16'h2960,16'h2960,16'h297E,16'h297E},
		'{16'h2A00,16'h2A00,16'h2A00,16'h2A00,16'h2A00,16'h2A00,16'h2A00,16'h2A00},
		'{16'h2B5C,16'h2B7C,16'h2B1C,16'h0000,16'h2B5C,16'h2B5C,16'h2B7C,16'h2B7C},
		'{16'h2C7A,16'h2C5A,16'h2C1A,16'h2C00,16'h2C7A,16'h2C5A,16'h2C7A,16'h2C5A},
		'{16'h2D78,16'h2D58,16'h2D18,16'h2D00,16'h2D78,16'h2D58,16'h2D78,16'h2D58},
		'{16'h2E63,16'h2E43,16'h2E03,16'h2E00,16'h2E63,16'h2E43,16'h2E63,16'h2E43},
		'{16'h2F76,16'h2F56,16'h2F16,16'h2F00,16'h2F76,16'h2F56,16'h2F76,16'h2F56},
		'{16'h3062,16'h3042,16'h3002,16'h3000,16'h3062,16'h3042,16'h3062,16'h3042},
		'{16'h316E,16'h314E,16'h310E,16'h3100,16'h316E,16'h314E,16'h316E,16'h314E},
		'{16'h326D,16'h324D,16'h320D,16'h3200,16'h326D,16'h324D,16'h326D,16'h324D},
		'{16'h332C,16'h333C,16'h0000,16'h0000,16'h332C,16'h332C,16'h333C,16'h333C},
		'{16'h342E,16'h343E,16'h0000,16'h0000,16'h342E,16'h342E,16'h343E,16'h343E},
		'{16'h352F,16'h353F,16'h0000,16'h0000,16'h352F,16'h352F,16'h353F,16'h353F},
		'{16'h3600,16'h3600,16'h3600,16'h3600,16'h3600,16'h3600,16'h3600,16'h3600},
		'{16'h372A,16'h0000,16'h3710,16'h0000,16'h372A,16'h372A,16'h0000,16'h0000},
		'{16'h3800,16'h3800,16'h3800,16'h3800,16'h3800,16'h3800,16'h3800,16'h3800},
		'{16'h3920,16'h3920,16'h3920,16'h0000,16'h3920,16'h3920,16'h3920,16'h3920},
		'{16'h3A00,16'h3A00,16'h3A00,16'h3A00,16'h3A00,16'h3A00,16'h3A00,16'h3A00},
		'{16'h3B00,16'h5400,16'h5E00,16'h6800,16'h3B00,16'h3B00,16'h5400,16'h5400},
		'{16'h3C00,16'h5500,16'h5F00,16'h6900,16'h3C00,16'h3C00,16'h5500,16'h5500},
		'{16'h3D00,16'h5600,16'h6000,16'h6A00,16'h3D00,16'h3D00,16'h5600,16'h5600},
		'{16'h3E00,16'h5700,16'h6100,16'h6B00,16'h3E00,16'h3E00,16'h5700,16'h5700},
		'{16'h3F00,16'h5800,16'h6200,16'h6C00,16'h3F00,16'h3F00,16'h5800,16'h5800},
		'{16'h4000,16'h5900,16'h6300,16'h6D00,16'h4000,16'h4000,16'h5900,16'h5900},
		'{16'h4100,16'h5A00,16'h6400,16'h6E00,16'h4100,16'h4100,16'h5A00,16'h5A00},
		'{16'h4200,16'h5B00,16'h6500,16'h6F00,16'h4200,16'h4200,16'h5B00,16'h5B00},
		'{16'h4300,16'h5C00,16'h6600,16'h7000,16'h4300,16'h4300,16'h5C00,16'h5C00},
		'{16'h4400,16'h5D00,16'h6700,16'h7100,16'h4400,16'h4400,16'h5D00,16'h5D00},
		'{16'h4500,16'h4500,16'h4500,16'h4500,16'h4500,16'h4500,16'h4500,16'h4500},
		'{16'h4600,16'h4600,16'h4600,16'h4600,16'h4600,16'h4600,16'h4600,16'h4600},
		'{16'h4700,16'h4737,16'h7700,16'h0000,16'h4737,16'h4700,16'h4737,16'h4700},
		'{16'h4800,16'h4838,16'h0000,16'h0000,16'h4838,16'h4800,16'h4838,16'h4800},
		'{16'h4900,16'h4939,16'h8400,16'h0000,16'h4939,16'h4900,16'h4939,16'h4900},
		'{16'h4A2D,16'h4A2D,16'h0000,16'h0000,16'h4A2D,16'h4A2D,16'h4A2D,16'h4A2D},
		'{16'h4B00,16'h4B00,16'h7300,16'h4B00,16'h4B00,16'h4B00,16'h4B00,16'h4B00},
		'{16'h4C00,16'h4C35,16'h0000,16'h0000,16'h4C35,16'h4C00,16'h4C35,16'h4C00},
		'{16'h4D00,16'h4D00,16'h7400,16'h4D00,16'h4D00,16'h4D00,16'h4D00,16'h4D00},
		'{16'h4E2B,16'h4E2B,16'h0000,16'h0000,16'h4E2B,16'h4E2B,16'h4E2B,16'h4E2B},
		'{16'h4F00,16'h4F31,16'h7500,16'h0000,16'h4F31,16'h4F00,16'h4F31,16'h4F00},
		'{16'h5000,16'h5032,16'h0000,16'h0000,16'h5032,16'h5000,16'h5032,16'h5000},
		'{16'h5100,16'h5133,16'h7600,16'h0000,16'h5133,16'h5100,16'h5133,16'h5100},
		'{16'h5200,16'h5230,16'h0000,16'h0000,16'h5230,16'h5200,16'h5230,16'h5200},
		'{16'h5300,16'h532E,16'h0000,16'h0000,16'h532E,16'h5300,16'h532E,16'h5300},
		'{16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000},
		'{16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000},
		'{16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000},
		'{16'h5700,16'h0000,16'h0000,16'h0000,16'h5700,16'h5700,16'h0000,16'h0000},
		'{16'h5800,16'h0000,16'h0000,16'h0000,16'h5800,16'h5800,16'h0000,16'h0000}
	};

	function automatic logic [7:0] map_extended(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			8'h11: r = 8'h38;
			8'h12: r = 8'h37;
			8'h14: r = 8'h1D;
			8'h4A: r = 8'h35;
			8'h5A: r = 8'h1C;
			8'h69: r = 8'h4F;
			8'h6B: r = 8'h4B;
			8'h6C: r = 8'h47;
			8'h70: r = 8'h52;
			8'h71: r = 8'h53;
			8'h72: r = 8'h50;
			8'h74: r = 8'h4D;
			8'h75: r = 8'h48;
			8'h7A: r = 8'h51;
			8'h7D: r = 8'h49;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/ps2kt_decode.sv
module ps2kt_decode (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] raw_byte,
	output logic [7:0] scan,
	output logic       reply
);

	logic release_q;
	logic extended_q;
	logic release_d;
	logic extended_d;

	always_comb begin
		scan = 8'h00;
		reply = 1'b0;
		release_d = release_q;
		extended_d = extended_q;
		if (raw_byte == ps2kt_pkg::RAW_SELF_TEST) begin
			reply = 1'b1;
		end else if (raw_byte == ps2kt_pkg::RAW_BREAK) begin
			release_d = 1'b1;
			extended_d = 1'b0;
		end else if (raw_byte == ps2kt_pkg::RAW_EXTENDED) begin
			extended_d = 1'b1;
		end else if (release_q) begin
			release_d = 1'b0;
			unique case (raw_byte)
				8'h59: scan = ps2kt_pkg::SC_RSHIFT_BREAK;
				8'h12: scan = ps2kt_pkg::SC_LSHIFT_BREAK;
				8'h14: scan = ps2kt_pkg::SC_CTRL_BREAK;
				8'h11: scan = ps2kt_pkg::SC_ALT_BREAK;
				default: scan = 8'h00;
			endcase
		end else if (extended_q) begin
			extended_d = 1'b0;
			scan = ps2kt_pkg::map_extended(raw_byte);
		end else if (raw_byte < 8'(ps2kt_pkg::RAW_ROWS)) begin
			scan = ps2kt_pkg::PLAIN_ROM[raw_byte];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= 1'b0;
			extended_q <= 1'b0;
		end else if (step) begin
			release_q <= release_d;
			extended_q <= extended_d;
		end
	end

endmodule

// File: rtl/ps2kt_word.sv
module ps2kt_word (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            scan,
	input  logic                  reply,
	output ps2kt_pkg::result_t    res
);

	ps2kt_pkg::mod_state_t mods_q;
	ps2kt_pkg::mod_state_t mods_d;
	ps2kt_pkg::word_col_t  col;
	logic is_mod;
	logic sh;

	always_comb begin
		mods_d = mods_q;
		is_mod = 1'b1;
		unique case (scan)
			ps2kt_pkg::SC_RSHIFT_MAKE:  mods_d.right_shift = 1'b1;
			ps2kt_pkg::SC_RSHIFT_BREAK: mods_d.right_shift = 1'b0;
			ps2kt_pkg::SC_LSHIFT_MAKE:  mods_d.left_shift = 1'b1;
			ps2kt_pkg::SC_LSHIFT_BREAK: mods_d.left_shift = 1'b0;
			ps2kt_pkg::SC_ALT_MAKE:     mods_d.alt = 1'b1;
			ps2kt_pkg::SC_ALT_BREAK:    mods_d.alt = 1'b0;
			ps2kt_pkg::SC_CTRL_MAKE:    mods_d.ctrl = 1'b1;
			ps2kt_pkg::SC_CTRL_BREAK:   mods_d.ctrl = 1'b0;
			ps2kt_pkg::SC_CAPS:         mods_d.locks[0] = ~mods_q.locks[0];
			ps2kt_pkg::SC_NUM:          mods_d.locks[1] = ~mods_q.locks[1];
			ps2kt_pkg::SC_SCROLL:       mods_d.locks[2] = ~mods_q.locks[2];
			ps2kt_pkg::SC_INSERT:       mods_d.locks[3] = ~mods_q.locks[3];
			ps2kt_pkg::SC_CAPS_BREAK, ps2kt_pkg::SC_SCROLL_BREAK,
			ps2kt_pkg::SC_NUM_BREAK, ps2kt_pkg::SC_INSERT_BREAK: is_mod = 1'b1;
			default: is_mod = 1'b0;
		endcase

		sh = mods_q.left_shift | mods_q.right_shift;
		priority if (mods_q.alt) col = ps2kt_pkg::COL_ALT;
		else if (mods_q.ctrl) col = ps2kt_pkg::COL_CTRL;
		else if (scan >= ps2kt_pkg::KEYPAD_FIRST && mods_q.locks[1])
			col = sh ? ps2kt_pkg::COL_SHIFT_NUM : ps2kt_pkg::COL_NUM;
		else if (scan < ps2kt_pkg::KEYPAD_FIRST && mods_q.locks[0])
			col = sh ? ps2kt_pkg::COL_SHIFT_CAPS : ps2kt_pkg::COL_CAPS;
		else col = sh ? ps2kt_pkg::COL_SHIFT : ps2kt_pkg::COL_NORMAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
		end else if (step) begin
			mods_q <= mods_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res.key_valid <= (scan != 8'h00) && !is_mod;
			res.key_word <= ((scan != 8'h00) && !is_mod &&
				scan < 8'(ps2kt_pkg::WORD_ROWS)) ?
				ps2kt_pkg::WORD_ROM[7'(scan)][col] : 16'h0000;
			res.reply_needed <= reply;
			res.last_scan <= scan;
			res.mods <= mods_d;
		end
	end

endmodule

// File: rtl/ps2_set2_keyboard_translator.sv
// The result item for an accepted byte is registered and appears in the cycle after the accept.
// Throughput: one byte per cycle while out_ready is high; the result register frees as it is taken.
// The prefix flags and modifier/lock state update in the accept cycle.
// arst_n clears prefix flags, modifiers, locks and the output valid.
module ps2_set2_keyboard_translator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  raw_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        key_valid,
	output logic [15:0] key_word,
	output logic        reply_needed,
	output logic [7:0]  last_scan,
	output logic        shift_down,
	output logic        ctrl_down,
	output logic        alt_down,
	output logic        caps_lock,
	output logic        num_lock,
	output logic        scroll_lock,
	output logic        insert_mode
);

	logic step;
	logic [7:0] scan;
	logic reply;
	logic out_valid_q;
	ps2kt_pkg::result_t res;

	assign in_ready = !out_valid_q || out_ready;
	assign step = in_valid && in_ready;

	ps2kt_decode u_decode (
		.clk(clk), .arst_n(arst_n), .step(step), .raw_byte(raw_byte),
		.scan(scan), .reply(reply)
	);

	ps2kt_word u_word (
		.clk(clk), .arst_n(arst_n), .step(step), .scan(scan), .reply(reply),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	assign out_valid = out_valid_q;
	assign key_valid = res.key_valid;
	assign key_word = res.key_word;
	assign reply_needed = res.reply_needed;
	assign last_scan = res.last_scan;
	assign shift_down = res.mods.left_shift | res.mods.right_shift;
	assign ctrl_down = res.mods.ctrl;
	assign alt_down = res.mods.alt;
	assign caps_lock = res.mods.locks[0];
	assign num_lock = res.mods.locks[1];
	assign scroll_lock = res.mods.locks[2];
	assign insert_mode = res.mods.locks[3];

endmodule
